[design/vlfc_pkg.sv]
// Shared types, constants and codes for the vehicle lamp flasher controller.
// Used by vlfc_core and vehicle_lamp_flasher_controller; depends on nothing else.
package vlfc_pkg;

    localparam int unsigned DUTY_W       = 14;
    localparam int unsigned HALF_W       = 6;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned STEP_W       = 6;
    localparam int unsigned FLAG_W       = 8;
    localparam int unsigned CHANNELS     = 4;

    localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = 6'd16;
    localparam logic [STEP_W-1:0]  DEMO_LAST_STEP    = 6'd48;

    localparam logic [DUTY_W-1:0]  FULL_DUTY       = 14'd10000;
    localparam logic [DUTY_W-1:0]  BRAKE_REAR_DUTY = 14'd5000;
    localparam logic [DUTY_W-1:0]  FRONT_POS_DUTY  = 14'd7000;
    localparam logic [DUTY_W-1:0]  REAR_POS_DUTY   = 14'd2500;
    localparam logic [DUTY_W-1:0]  DUTY_OFF        = 14'd0;

    // Item kinds.
    localparam logic [2:0] KIND_TICK         = 3'd0;
    localparam logic [2:0] KIND_SELECT       = 3'd1;
    localparam logic [2:0] KIND_BRAKE_ON     = 3'd2;
    localparam logic [2:0] KIND_BRAKE_OFF    = 3'd3;
    localparam logic [2:0] KIND_POSITION_ON  = 3'd4;
    localparam logic [2:0] KIND_POSITION_OFF = 3'd5;
    localparam logic [2:0] KIND_DEMO_ON      = 3'd6;
    localparam logic [2:0] KIND_DEMO_OFF     = 3'd7;

    // Blink selections; anything above hazard clears every selection.
    localparam logic [2:0] SEL_DISABLE = 3'd0;
    localparam logic [2:0] SEL_RIGHT   = 3'd1;
    localparam logic [2:0] SEL_LEFT    = 3'd2;
    localparam logic [2:0] SEL_HAZARD  = 3'd3;

    // Bit positions in the lamp flag byte.
    localparam int unsigned FLAG_DIS   = 0;
    localparam int unsigned FLAG_RIGHT = 1;
    localparam int unsigned FLAG_LEFT  = 2;
    localparam int unsigned FLAG_HAZ   = 3;
    localparam int unsigned FLAG_BRAKE = 4;
    localparam int unsigned FLAG_FRONT = 5;
    localparam int unsigned FLAG_REAR  = 6;
    localparam int unsigned FLAG_DEMO  = 7;

    // Duty channel numbers.
    localparam int unsigned CH_BRAKE = 0;
    localparam int unsigned CH_RIGHT = 1;
    localparam int unsigned CH_LEFT  = 2;
    localparam int unsigned CH_FRONT = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] blink_select;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0] brake_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] front_duty;
        logic              indicator_pad;
        logic              right_shown;
        logic              left_shown;
        logic              hazard_shown;
        logic              front_lamp_on;
        logic              braking_on;
        logic              demo_on;
        logic              blink_disabled;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0]               blink_counter;
        logic                             blink_ready;
        logic                             right_on_phase;
        logic                             left_on_phase;
        logic [STEP_W-1:0]                demo_step;
        logic [FLAG_W-1:0]                lamp_flags;
        logic [CHANNELS-1:0][DUTY_W-1:0]  channel_duty;
        logic                             pad_level;
    } lamp_state_t;

endpackage

[design/vlfc_core.sv]
// Next-state and result logic for one item of the lamp controller.
// Depends on vlfc_pkg; purely combinational, registered by the top level.
module vlfc_core (
    input  vlfc_pkg::lamp_state_t          state,
    input  vlfc_pkg::in_word_t             item,
    input  logic [vlfc_pkg::HALF_W-1:0]    half_period,
    output vlfc_pkg::lamp_state_t          state_next,
    output vlfc_pkg::out_word_t            result
);
    import vlfc_pkg::*;

    always_comb
    begin
        lamp_state_t        st;
        logic [COUNT_W-1:0] cnt;
        logic [STEP_W-1:0]  s;
        logic [STEP_W:0]    s_inc;

        st    = state;
        cnt   = st.blink_counter + COUNT_W'(1);
        s     = st.demo_step;
        s_inc = {1'b0, s} + (STEP_W+1)'(1);

        case (item.kind)
            KIND_TICK:
            begin
                // Indicator blink: on phase, off phase, then rearm.
                if (cnt > {half_period, 1'b0})
                begin
                    cnt            = '0;
                    st.blink_ready = 1'b1;
                end
                else if (cnt > {1'b0, half_period})
                begin
                    st.channel_duty[CH_RIGHT] = DUTY_OFF;
                    st.channel_duty[CH_LEFT]  = DUTY_OFF;
                    st.pad_level              = 1'b0;
                    st.right_on_phase         = 1'b0;
                    st.left_on_phase          = 1'b0;
                end
                else
                begin
                    if (st.lamp_flags[FLAG_RIGHT] && st.blink_ready)
                    begin
                        st.channel_duty[CH_RIGHT] = FULL_DUTY;
                        st.pad_level              = 1'b1;
                        st.blink_ready            = 1'b0;
                        st.right_on_phase         = 1'b1;
                    end
                    if (st.lamp_flags[FLAG_LEFT] && st.blink_ready)
                    begin
                        st.channel_duty[CH_LEFT] = FULL_DUTY;
                        st.pad_level             = 1'b1;
                        st.blink_ready           = 1'b0;
                        st.left_on_phase         = 1'b1;
                    end
                    // A hazard flash leaves the pad alone.
                    if (st.lamp_flags[FLAG_HAZ] && st.blink_ready)
                    begin
                        st.channel_duty[CH_RIGHT] = FULL_DUTY;
                        st.channel_duty[CH_LEFT]  = FULL_DUTY;
                        st.blink_ready            = 1'b0;
                        st.right_on_phase         = 1'b1;
                        st.left_on_phase          = 1'b1;
                    end
                end
                st.blink_counter = cnt;

                if (st.lamp_flags[FLAG_DIS])
                begin
                    st.channel_duty[CH_RIGHT] = DUTY_OFF;
                    st.channel_duty[CH_LEFT]  = DUTY_OFF;
                end

                // Demo: three front flashes, then three hazard flashes.
                if (st.lamp_flags[FLAG_DEMO])
                begin
                    if (s == 6'd0 || s == 6'd4 || s == 6'd8)
                    begin
                        st.channel_duty[CH_FRONT] = FULL_DUTY;
                        st.lamp_flags[FLAG_FRONT] = 1'b1;
                    end
                    else if (s == 6'd1 || s == 6'd5 || s == 6'd9)
                    begin
                        st.channel_duty[CH_FRONT] = DUTY_OFF;
                        st.lamp_flags[FLAG_FRONT] = 1'b0;
                    end
                    if (s == 6'd14 || s == 6'd18 || s == 6'd22)
                    begin
                        st.channel_duty[CH_RIGHT] = FULL_DUTY;
                        st.channel_duty[CH_LEFT]  = FULL_DUTY;
                        st.lamp_flags[FLAG_HAZ]   = 1'b1;
                    end
                    else if (s == 6'd15 || s == 6'd19 || s == 6'd23)
                    begin
                        st.channel_duty[CH_RIGHT] = DUTY_OFF;
                        st.channel_duty[CH_LEFT]  = DUTY_OFF;
                        st.lamp_flags[FLAG_HAZ]   = 1'b0;
                    end
                    st.demo_step = (s_inc > {1'b0, DEMO_LAST_STEP}) ? '0 : s_inc[STEP_W-1:0];
                end

                if (!st.lamp_flags[FLAG_DEMO] && !st.lamp_flags[FLAG_FRONT])
                begin
                    st.channel_duty[CH_FRONT] = DUTY_OFF;
                end
                if (!st.lamp_flags[FLAG_DEMO] && !st.lamp_flags[FLAG_HAZ]
                    && !st.lamp_flags[FLAG_RIGHT] && !st.lamp_flags[FLAG_LEFT])
                begin
                    st.channel_duty[CH_RIGHT] = DUTY_OFF;
                    st.channel_duty[CH_LEFT]  = DUTY_OFF;
                end
            end
            KIND_SELECT:
            begin
                st.lamp_flags[FLAG_DIS]   = (item.blink_select == SEL_DISABLE);
                st.lamp_flags[FLAG_RIGHT] = (item.blink_select == SEL_RIGHT);
                st.lamp_flags[FLAG_LEFT]  = (item.blink_select == SEL_LEFT);
                st.lamp_flags[FLAG_HAZ]   = (item.blink_select == SEL_HAZARD);
                st.blink_counter          = '0;
                st.blink_ready            = 1'b1;
            end
            KIND_BRAKE_ON:
            begin
                st.lamp_flags[FLAG_BRAKE] = 1'b1;
                st.channel_duty[CH_BRAKE] = FULL_DUTY;
            end
            KIND_BRAKE_OFF:
            begin
                st.lamp_flags[FLAG_BRAKE] = 1'b0;
                st.channel_duty[CH_BRAKE] = st.lamp_flags[FLAG_REAR] ? BRAKE_REAR_DUTY : DUTY_OFF;
            end
            KIND_POSITION_ON:
            begin
                st.lamp_flags[FLAG_FRONT] = 1'b1;
                st.lamp_flags[FLAG_REAR]  = 1'b1;
                st.channel_duty[CH_FRONT] = FRONT_POS_DUTY;
                st.channel_duty[CH_BRAKE] = REAR_POS_DUTY;
            end
            KIND_POSITION_OFF:
            begin
                st.lamp_flags[FLAG_FRONT] = 1'b0;
                st.lamp_flags[FLAG_REAR]  = 1'b0;
                st.channel_duty[CH_FRONT] = DUTY_OFF;
                st.channel_duty[CH_BRAKE] = DUTY_OFF;
            end
            KIND_DEMO_ON:
            begin
                st.lamp_flags[FLAG_DEMO] = 1'b1;
            end
            default:
            begin
                st.lamp_flags[FLAG_DEMO] = 1'b0;
            end
        endcase

        state_next = st;

        result.brake_duty     = st.channel_duty[CH_BRAKE];
        result.right_duty     = st.channel_duty[CH_RIGHT];
        result.left_duty      = st.channel_duty[CH_LEFT];
        result.front_duty     = st.channel_duty[CH_FRONT];
        result.indicator_pad  = st.pad_level;
        result.right_shown    = st.right_on_phase && st.lamp_flags[FLAG_RIGHT];
        result.left_shown     = st.left_on_phase && st.lamp_flags[FLAG_LEFT];
        result.hazard_shown   = st.right_on_phase && st.left_on_phase && st.lamp_flags[FLAG_HAZ];
        result.front_lamp_on  = st.lamp_flags[FLAG_FRONT];
        result.braking_on     = st.lamp_flags[FLAG_BRAKE];
        result.demo_on        = st.lamp_flags[FLAG_DEMO];
        result.blink_disabled = st.lamp_flags[FLAG_DIS];
    end

endmodule

[design/vehicle_lamp_flasher_controller.sv]
// Top level of the vehicle lamp flasher controller: state, result register, config.
// Depends on vlfc_pkg and vlfc_core.
//
// Usage:
// The input channel (in_valid, in_ready, in_word) carries one word per item:
// either a tick, which advances the indicator blink and the demo pattern, or
// a command (blink selection, brake, position lamps, demo on or off).
// For every accepted word the output channel (out_valid, out_ready, out_word)
// delivers exactly one word holding all four channel duties, the indicator
// pad level and the status flags as they stand after that item.
// The result is registered and appears in the cycle after acceptance. One item per
// cycle is sustained while out_ready stays high: the whole update is a single
// combinational pass in vlfc_core between the lamp state and result registers.
// When the receiver stalls, the result register holds its word and in_ready
// drops; in_ready stays high while the result register is empty or is being
// drained in the same cycle, so no bubble is ever inserted.
// The blink half period is written through cfg_wr_en and cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce; it takes effect on the next tick.
// Reset (rst_n low, asynchronous) clears every lamp flag, counter and duty,
// empties the result register and sets the half period to 16 ticks.
module vehicle_lamp_flasher_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vlfc_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vlfc_pkg::out_word_t           out_word,
    input  logic                          cfg_wr_en,
    input  logic [vlfc_pkg::HALF_W-1:0]   cfg_wr_data
);
    import vlfc_pkg::*;

    lamp_state_t        state_reg;
    lamp_state_t        state_next;
    out_word_t          out_word_reg;
    out_word_t          out_word_next;
    logic               out_valid_reg;
    logic [HALF_W-1:0]  half_period_reg;
    logic               accept;

    // A new item may enter whenever the result register is free or leaving.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    vlfc_core u_core (
        .state       (state_reg),
        .item        (in_word),
        .half_period (half_period_reg),
        .state_next  (state_next),
        .result      (out_word_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            out_valid_reg   <= 1'b0;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                half_period_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result word itself needs no reset; it is only seen with out_valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // A tick always leaves the blink counter within the whole blink cycle.
    a_counter_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.kind == KIND_TICK
        |=> {1'b0, state_reg.blink_counter} <= {1'b0, $past(half_period_reg), 1'b0})
        else $error("blink counter beyond blink cycle after tick");

    // The demo step never runs past its last step.
    a_demo_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.demo_step <= DEMO_LAST_STEP)
        else $error("demo step out of range");

    // A disable selection sets only the disable flag among the blink selections.
    a_disable_select: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.kind == KIND_SELECT && in_word.blink_select == SEL_DISABLE
        |=> state_reg.lamp_flags[FLAG_DIS] && !state_reg.lamp_flags[FLAG_RIGHT]
            && !state_reg.lamp_flags[FLAG_LEFT] && !state_reg.lamp_flags[FLAG_HAZ]
            && state_reg.blink_ready && out_word_reg.blink_disabled)
        else $error("disable selection did not take effect");

    // The state only moves when an item is accepted.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("lamp state changed without an accepted item");

endmodule
